// File: src/timer_slot_scheduler_macros.svh
// Assertion macros shared by the timer slot scheduler checks.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef TIMER_SLOT_SCHEDULER_MACROS_SVH
`define TIMER_SLOT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer slot scheduler check failed");

// Next-cycle implication, disabled during reset
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer slot scheduler check failed");

`endif

// File: src/tss_pkg.sv
// Types and constants of the timer slot scheduler.
// Used by the controller, the datapath, the top level and the checker.
package tss_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_START_ONE = 2'd1;
    localparam logic [1:0] OP_START_PER = 2'd2;
    localparam logic [1:0] OP_CANCEL    = 2'd3;

    // Event codes of a result beat
    localparam logic [2:0] EV_STARTED   = 3'd0;
    localparam logic [2:0] EV_FIRED     = 3'd1;
    localparam logic [2:0] EV_CANCELLED = 3'd2;
    localparam logic [2:0] EV_NOFREE    = 3'd3;
    localparam logic [2:0] EV_MISSED    = 3'd4;

    // Cap on fire results reported for one tick
    localparam int MaxResults = 16;
    localparam int CntW       = $clog2(MaxResults + 1);

    localparam int TimeW   = 32;
    localparam int PeriodW = 31;
    localparam int IdW     = 4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] interval;
        logic [3:0]         slot;
    } in_item_t;

    typedef struct packed {
        logic [IdW-1:0] timer_id;
        logic [2:0]     event_res;
        logic           last;
    } out_item_t;

    // One slot of the timer memory
    typedef struct packed {
        logic               repeats;
        logic [PeriodW-1:0] period;
        logic [TimeW-1:0]   deadline;
    } slot_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic tick;
        logic rd_issue;
        logic find;
        logic cancel;
        logic flush;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic idx_last;
        logic free_hit;
    } ctl_sts_t;

endpackage

// File: src/timer_slot_scheduler.sv
// Timer slot scheduler: a tick scans every slot, start allocates, cancel frees.
// A start searches the slots in order for a free one; a tick reads one slot per cycle
// from the slot memory, and fire beats stream out during the scan, at most one per cycle.
// Results appear as one-cycle strobed beats; the block takes the next item as soon as
// busy is low. Reset clears time, busy flags and the sequencer.
module timer_slot_scheduler
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tss_pkg::in_item_t   item,
    output logic                result_valid,
    output tss_pkg::out_item_t  result
);

    localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    tss_pkg::ctl_cmd_t cmd;
    tss_pkg::ctl_sts_t sts;

    tss_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    tss_datapath
    #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IdxW)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// File: src/tss_ctrl.sv
// Sequencer of the timer slot scheduler: steps scans, allocation and cancel.
// Depends on tss_pkg for opcodes and the command and status structs.
module tss_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          op,
    input  tss_pkg::ctl_sts_t   sts,
    output logic                busy,
    output tss_pkg::ctl_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TREAD  = 3'd1;
    localparam logic [2:0] S_TDRAIN = 3'd2;
    localparam logic [2:0] S_TFLUSH = 3'd3;
    localparam logic [2:0] S_FIND   = 3'd4;
    localparam logic [2:0] S_CANCEL = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    // Decode state into next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (op) inside
                        tss_pkg::OP_TICK:
                        begin
                            cmd.tick   = 1'b1;
                            state_next = S_TREAD;
                        end
                        tss_pkg::OP_START_ONE, tss_pkg::OP_START_PER:
                        begin
                            state_next = S_FIND;
                        end
                        default:
                        begin
                            state_next = S_CANCEL;
                        end
                    endcase
                end
            end
            S_TREAD:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_TDRAIN;
                end
            end
            S_TDRAIN:
            begin
                state_next = S_TFLUSH;
            end
            S_TFLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            S_FIND:
            begin
                cmd.find = 1'b1;
                if (sts.free_hit || sts.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CANCEL:
            begin
                cmd.cancel = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/tss_datapath.sv
// Datapath of the timer slot scheduler: time counter, slot memory, busy flags,
// compare stage and result register. Depends on tss_pkg.
module tss_datapath
#(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tss_pkg::in_item_t   item,
    input  tss_pkg::ctl_cmd_t   cmd,
    output tss_pkg::ctl_sts_t   sts,
    output logic                result_valid,
    output tss_pkg::out_item_t  result
);

    localparam int SelW = (IDX_W > 4) ? IDX_W : 4;

    // Slot memory and its registered read
    tss_pkg::slot_entry_t mem [NUM_TIMERS];
    tss_pkg::slot_entry_t mem_rd_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    tss_pkg::slot_entry_t wr_data;

    logic [tss_pkg::TimeW-1:0]   now_reg,        now_next;
    logic [NUM_TIMERS-1:0]       busy_reg,       busy_next;
    logic [IDX_W-1:0]            idx_reg,        idx_next;
    logic [tss_pkg::PeriodW-1:0] ivl_reg,        ivl_next;
    logic                        periodic_reg,   periodic_next;
    logic [3:0]                  slot_reg,       slot_next;
    logic                        stage_vld_reg,  stage_vld_next;
    logic [IDX_W-1:0]            stage_idx_reg,  stage_idx_next;
    logic                        pend_vld_reg,   pend_vld_next;
    logic [IDX_W-1:0]            pend_id_reg,    pend_id_next;
    logic [tss_pkg::CntW-1:0]    cnt_reg,        cnt_next;
    logic                        res_vld_reg,    res_vld_next;
    tss_pkg::out_item_t          res_reg,        res_next;

    logic             idx_last;
    logic             free_hit;
    logic             stage_hit;
    logic             report;
    logic             slot_ok;
    logic [SelW-1:0]  slot_ext;
    logic [IDX_W-1:0] slot_idx;
    logic             cancel_hit;

    // Status of the current slot and of the compare stage
    assign idx_last  = (idx_reg == IDX_W'(NUM_TIMERS - 1));
    assign free_hit  = !busy_reg[idx_reg];
    assign stage_hit = stage_vld_reg && busy_reg[stage_idx_reg]
                       && (mem_rd_reg.deadline == now_reg);
    assign report    = stage_hit && (cnt_reg != tss_pkg::CntW'(tss_pkg::MaxResults));

    // Locate the slot named by a cancel
    assign slot_ok    = (32'(slot_reg) < 32'(NUM_TIMERS));
    assign slot_ext   = SelW'(slot_reg);
    assign slot_idx   = slot_ext[IDX_W-1:0];
    assign cancel_hit = slot_ok ? busy_reg[slot_idx] : 1'b0;

    assign sts.idx_last = idx_last;
    assign sts.free_hit = free_hit;
    assign rd_en        = cmd.rd_issue;

    // Pick the memory write: allocation or periodic re-arm
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = mem_rd_reg;
        if (cmd.find && free_hit)
        begin
            wr_en            = 1'b1;
            wr_addr          = idx_reg;
            wr_data.repeats  = periodic_reg;
            wr_data.period   = ivl_reg;
            wr_data.deadline = now_reg + {1'b0, ivl_reg};
        end
        else if (stage_hit && mem_rd_reg.repeats)
        begin
            wr_en            = 1'b1;
            wr_addr          = stage_idx_reg;
            wr_data.deadline = now_reg + {1'b0, mem_rd_reg.period};
        end
    end

    // Advance time, flags, scan and results
    always_comb
    begin
        now_next       = now_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        ivl_next       = ivl_reg;
        periodic_next  = periodic_reg;
        slot_next      = slot_reg;
        stage_vld_next = 1'b0;
        stage_idx_next = stage_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_id_next   = pend_id_reg;
        cnt_next       = cnt_reg;
        res_vld_next   = 1'b0;
        res_next       = res_reg;

        if (cmd.load)
        begin
            idx_next      = '0;
            pend_vld_next = 1'b0;
            cnt_next      = '0;
            slot_next     = item.slot;
            periodic_next = (item.op == tss_pkg::OP_START_PER);
            if (item.interval <= 32'sd0)
            begin
                ivl_next = tss_pkg::PeriodW'(1);
            end
            else
            begin
                ivl_next = item.interval[tss_pkg::PeriodW-1:0];
            end
        end

        if (cmd.tick)
        begin
            now_next = now_reg + tss_pkg::TimeW'(1);
        end

        // Issue one slot read per cycle
        if (cmd.rd_issue)
        begin
            idx_next       = idx_reg + IDX_W'(1);
            stage_vld_next = 1'b1;
            stage_idx_next = idx_reg;
        end

        // Fire: re-arm or free, and hold the report back until the next one
        if (stage_hit)
        begin
            if (!mem_rd_reg.repeats)
            begin
                busy_next[stage_idx_reg] = 1'b0;
            end
            if (report)
            begin
                if (pend_vld_reg)
                begin
                    res_vld_next       = 1'b1;
                    res_next.timer_id  = tss_pkg::IdW'(pend_id_reg);
                    res_next.event_res = tss_pkg::EV_FIRED;
                    res_next.last      = 1'b0;
                end
                pend_vld_next = 1'b1;
                pend_id_next  = stage_idx_reg;
                cnt_next      = cnt_reg + tss_pkg::CntW'(1);
            end
        end

        // Drop the held report as the final beat of the tick
        if (cmd.flush && pend_vld_reg)
        begin
            res_vld_next       = 1'b1;
            res_next.timer_id  = tss_pkg::IdW'(pend_id_reg);
            res_next.event_res = tss_pkg::EV_FIRED;
            res_next.last      = 1'b1;
            pend_vld_next      = 1'b0;
        end

        // Search for a free slot
        if (cmd.find)
        begin
            if (free_hit)
            begin
                busy_next[idx_reg] = 1'b1;
                res_vld_next       = 1'b1;
                res_next.timer_id  = tss_pkg::IdW'(idx_reg);
                res_next.event_res = tss_pkg::EV_STARTED;
                res_next.last      = 1'b1;
            end
            else if (idx_last)
            begin
                res_vld_next       = 1'b1;
                res_next.timer_id  = '0;
                res_next.event_res = tss_pkg::EV_NOFREE;
                res_next.last      = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        if (cmd.cancel)
        begin
            if (cancel_hit)
            begin
                busy_next[slot_idx] = 1'b0;
                res_next.event_res  = tss_pkg::EV_CANCELLED;
            end
            else
            begin
                res_next.event_res = tss_pkg::EV_MISSED;
            end
            res_vld_next      = 1'b1;
            res_next.timer_id = slot_reg;
            res_next.last     = 1'b1;
        end
    end

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[idx_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            busy_reg      <= '0;
            idx_reg       <= '0;
            stage_vld_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
            cnt_reg       <= '0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            now_reg       <= now_next;
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            stage_vld_reg <= stage_vld_next;
            pend_vld_reg  <= pend_vld_next;
            cnt_reg       <= cnt_next;
            res_vld_reg   <= res_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ivl_reg       <= ivl_next;
        periodic_reg  <= periodic_next;
        slot_reg      <= slot_next;
        stage_idx_reg <= stage_idx_next;
        pend_id_reg   <= pend_id_next;
        res_reg       <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

// File: src/tss_checker.sv
// Port-level checks of the timer slot scheduler, bound to the top level.
// Depends on tss_pkg and timer_slot_scheduler_macros.svh.
`include "timer_slot_scheduler_macros.svh"

module tss_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input tss_pkg::in_item_t   item,
    input logic                result_valid,
    input tss_pkg::out_item_t  result
);

    // An accepted beat occupies the block in the next cycle
    `TSS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // The final beat of an item comes with the block already free
    `TSS_ASSERT_NOW(a_last_idle, clk, rst_n, result_valid && result.last, !busy)

    // Only fire beats can be followed by more beats of the same item
    `TSS_ASSERT_NOW(a_nonlast_fire, clk, rst_n, result_valid && !result.last,
        (result.event_res == tss_pkg::EV_FIRED) && busy)

    // Start and cancel answers are single beats
    `TSS_ASSERT_NOW(a_single_beat, clk, rst_n,
        result_valid && (result.event_res == tss_pkg::EV_STARTED
        || result.event_res == tss_pkg::EV_CANCELLED
        || result.event_res == tss_pkg::EV_NOFREE
        || result.event_res == tss_pkg::EV_MISSED), result.last)

endmodule

bind timer_slot_scheduler tss_checker u_tss_checker (.*);

// File: tb/tb_timer_slot_scheduler.sv
// Testbench of timer_slot_scheduler: directed and random tick, start and cancel beats.
// It predicts every fire, start and cancel event in order and compares each result beat.
// Depends on tss_pkg and the timer_slot_scheduler top level only.
module tb_timer_slot_scheduler;

    localparam int SLOTS = 16;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    tss_pkg::in_item_t item;
    logic result_valid;
    tss_pkg::out_item_t result;

    // Predicted scheduler state
    logic [31:0] model_now;
    logic [31:0] slot_deadline [SLOTS];
    logic [30:0] slot_period [SLOTS];
    logic slot_periodic [SLOTS];
    logic slot_armed [SLOTS];

    tss_pkg::out_item_t expected_events [$];
    tss_pkg::out_item_t want;
    int mismatch_count;
    int burst_left;

    timer_slot_scheduler #(
        .NUM_TIMERS(SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .result_valid(result_valid),
        .result(result)
    );

    always #5 clk = ~clk;

    function automatic tss_pkg::in_item_t make_item(logic [1:0] op, logic [31:0] ivl,
                                                    logic [3:0] slot);
        tss_pkg::in_item_t it;
        it.op = op;
        it.interval = ivl;
        it.slot = slot;
        return it;
    endfunction

    // Append one event at the tail of the expected queue
    task automatic queue_event(input tss_pkg::out_item_t e);
        expected_events.insert(expected_events.size(), e);
    endtask

    // Advance the predicted state by one accepted beat and queue the events it causes
    task automatic predict_timer_events(input tss_pkg::in_item_t it);
        tss_pkg::out_item_t ev;
        tss_pkg::out_item_t held;
        logic have_held;
        logic [31:0] raw;
        logic [31:0] ivl;
        logic found;
        have_held = 1'b0;
        found = 1'b0;
        held = '0;
        ev = '0;
        case (it.op)
            tss_pkg::OP_TICK:
            begin
                model_now = model_now + 32'd1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_armed[i] && slot_deadline[i] == model_now)
                    begin
                        if (slot_periodic[i])
                            slot_deadline[i] = model_now + {1'b0, slot_period[i]};
                        else
                            slot_armed[i] = 1'b0;
                        // Hold the newest fire back so the final one can carry last
                        if (have_held)
                            queue_event(held);
                        held.timer_id = i[3:0];
                        held.event_res = tss_pkg::EV_FIRED;
                        held.last = 1'b0;
                        have_held = 1'b1;
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    queue_event(held);
                end
            end
            tss_pkg::OP_START_ONE, tss_pkg::OP_START_PER:
            begin
                raw = it.interval;
                // Clamp zero and negative intervals to one tick
                if (raw == 32'd0 || raw[31])
                    ivl = 32'd1;
                else
                    ivl = raw;
                ev.timer_id = '0;
                ev.event_res = tss_pkg::EV_NOFREE;
                ev.last = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && !slot_armed[i])
                    begin
                        found = 1'b1;
                        slot_armed[i] = 1'b1;
                        slot_periodic[i] = (it.op == tss_pkg::OP_START_PER);
                        slot_period[i] = ivl[30:0];
                        slot_deadline[i] = model_now + ivl;
                        ev.timer_id = i[3:0];
                        ev.event_res = tss_pkg::EV_STARTED;
                    end
                end
                queue_event(ev);
            end
            default:
            begin
                ev.timer_id = it.slot;
                ev.last = 1'b1;
                if (slot_armed[it.slot])
                begin
                    slot_armed[it.slot] = 1'b0;
                    ev.event_res = tss_pkg::EV_CANCELLED;
                end
                else
                begin
                    ev.event_res = tss_pkg::EV_MISSED;
                end
                queue_event(ev);
            end
        endcase
    endtask

    // Send one beat in bursts with random gaps, then predict it at acceptance
    task automatic send_beat(input tss_pkg::in_item_t it);
        int gap;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(1, 8);
        end
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        predict_timer_events(it);
        burst_left--;
    endtask

    // Hold off the sender until every expected event has come, then let the block settle
    task automatic drain_events();
        start <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
    endtask

    // Fill every slot, overflow, then fire all sixteen on one tick
    task automatic test_fill_and_fire();
        send_beat(make_item(tss_pkg::OP_TICK, $urandom, 4'($urandom)));
        for (int i = 0; i < SLOTS; i++)
        begin
            send_beat(make_item(i[0] ? tss_pkg::OP_START_PER : tss_pkg::OP_START_ONE,
                                32'd2, 4'($urandom)));
        end
        send_beat(make_item(tss_pkg::OP_START_ONE, 32'd5, 4'd15));
        send_beat(make_item(tss_pkg::OP_TICK, 32'h8000_0000, 4'd0));
        send_beat(make_item(tss_pkg::OP_TICK, 32'h7fff_ffff, 4'd15));
    endtask

    // Cancel hits and misses, interval clamping and the interval extremes
    task automatic test_cancel_and_clamp();
        send_beat(make_item(tss_pkg::OP_CANCEL, 32'hffff_ffff, 4'd0));
        send_beat(make_item(tss_pkg::OP_CANCEL, 32'd0, 4'd15));
        send_beat(make_item(tss_pkg::OP_START_ONE, 32'd0, 4'd3));
        send_beat(make_item(tss_pkg::OP_START_PER, 32'h8000_0000, 4'd9));
        send_beat(make_item(tss_pkg::OP_START_ONE, 32'h7fff_ffff, 4'd1));
        send_beat(make_item(tss_pkg::OP_TICK, 32'd0, 4'd0));
        send_beat(make_item(tss_pkg::OP_TICK, 32'hffff_ffff, 4'd15));
        send_beat(make_item(tss_pkg::OP_CANCEL, 32'd1, 4'd4));
    endtask

    // Random mix of ticks, starts and cancels with mostly short intervals
    task automatic test_random_mix(input int count, input int tick_pct);
        logic [1:0] op;
        logic [31:0] ivl;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct)
                op = tss_pkg::OP_TICK;
            else if (pick < tick_pct + (100 - tick_pct) * 3 / 10)
                op = tss_pkg::OP_START_ONE;
            else if (pick < tick_pct + (100 - tick_pct) * 6 / 10)
                op = tss_pkg::OP_START_PER;
            else
                op = tss_pkg::OP_CANCEL;
            pick = $urandom_range(0, 99);
            if (pick < 65)
                ivl = $urandom_range(1, 12);
            else if (pick < 75)
                ivl = -$urandom_range(0, 3);
            else if (pick < 88)
                ivl = $urandom;
            else
            begin
                case ($urandom_range(0, 3))
                    0: ivl = 32'h7fff_ffff;
                    1: ivl = 32'h8000_0000;
                    2: ivl = 32'hffff_ffff;
                    default: ivl = 32'h0000_0001;
                endcase
            end
            send_beat(make_item(op, ivl, 4'($urandom)));
        end
    endtask

    // Compare each result beat with the oldest expected event
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_events.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result id=%0d ev=%0d last=%0d", $time,
                         result.timer_id, result.event_res, result.last);
            end
            else
            begin
                want = expected_events.pop_front();
                if (result.timer_id !== want.timer_id)
                begin
                    mismatch_count++;
                    $display("%0t: timer_id expected %0d actual %0d", $time,
                             want.timer_id, result.timer_id);
                end
                if (result.event_res !== want.event_res)
                begin
                    mismatch_count++;
                    $display("%0t: event_res expected %0d actual %0d", $time,
                             want.event_res, result.event_res);
                end
                if (result.last !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, result.last);
                end
            end
        end
    end

    // Bound the run
    initial
    begin
        #2000000;
        $display("FAIL timer_slot_scheduler");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        burst_left = 0;
        mismatch_count = 0;
        model_now = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_armed[i] = 1'b0;
            slot_periodic[i] = 1'b0;
            slot_period[i] = '0;
            slot_deadline[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_fire();
        drain_events();
        test_cancel_and_clamp();
        drain_events();
        test_random_mix(250, 40);
        drain_events();
        test_random_mix(250, 60);
        drain_events();

        if (mismatch_count == 0)
            $display("PASS timer_slot_scheduler");
        else
            $display("FAIL timer_slot_scheduler");
        $finish;
    end

endmodule
